>>> sv/text_tokenizer_with_comments_macros.svh
// Assertion macros shared by the tokenizer checker.
`ifndef TEXT_TOKENIZER_WITH_COMMENTS_MACROS_SVH
`define TEXT_TOKENIZER_WITH_COMMENTS_MACROS_SVH

// Property checked on every edge while out of reset.
`define TTOK_ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// Antecedent on one edge implies consequent on the next, out of reset.
`define TTOK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Antecedent on one edge implies consequent on the next, reset included.
`define TTOK_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> sv/ttok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ttok_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    // Results one byte can cause, and queue sizing
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = 2;
    localparam int RES_CNT_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_TOKEN   = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_DISCARD = 2'd3
    } scan_mode_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_END  = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   token_byte;
    } result_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [RES_CNT_W-1:0]          cnt;
        result_t [MAX_RESULTS-1:0]     res;
    } result_group_t;

    // Queue status towards the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> sv/ttok_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ttok_front (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [7:0]                 s_text_byte,
    input  wire                        cfg_valid,
    input  wire  [7:0]                 cfg_max_token_length,
    input  ttok_pkg::queue_status_t    q_status,
    output logic                       q_push,
    output ttok_pkg::result_group_t    q_group
);

    ttok_pkg::scan_mode_t mode_reg, mode_next, mode_calc;
    logic [7:0]           len_reg, len_next, len_calc;
    logic                 pend_reg, pend_next, pend_calc;
    logic [7:0]           max_len_reg;
    logic                 accept;
    logic                 sep;
    logic                 single;
    logic                 done;
    logic [2:0]           n;
    ttok_pkg::result_t [ttok_pkg::MAX_RESULTS-1:0] res;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // Hold the length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= ttok_pkg::MAX_LEN_RESET;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_max_token_length;
        end
    end

    // Hold scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ttok_pkg::MODE_BETWEEN;
            len_reg  <= 8'd0;
            pend_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            pend_reg <= pend_next;
        end
    end

    // Classify the byte and build its result group
    always_comb begin
        sep    = s_text_byte inside {ttok_pkg::CH_SPACE, ttok_pkg::CH_LF, ttok_pkg::CH_NUL};
        single = s_text_byte inside {ttok_pkg::CH_LBRACE, ttok_pkg::CH_RBRACE,
                                     ttok_pkg::CH_QUOTE, ttok_pkg::CH_LBRACK,
                                     ttok_pkg::CH_RBRACK};
        mode_calc = mode_reg;
        len_calc  = len_reg;
        pend_calc = pend_reg;
        done      = 1'b0;
        n         = 3'd0;
        res       = '0;

        // Resolve a held slash first
        if (pend_reg) begin
            pend_calc = 1'b0;
            if (s_text_byte == ttok_pkg::CH_SLASH) begin
                if (mode_calc == ttok_pkg::MODE_TOKEN) begin
                    res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                    n = n + 3'd1;
                end
                mode_calc = ttok_pkg::MODE_COMMENT;
                len_calc  = 8'd0;
                done      = 1'b1;
            end else begin
                res[n[1:0]] = '{ttok_pkg::KIND_BYTE, ttok_pkg::CH_SLASH};
                n = n + 3'd1;
                len_calc = len_calc + 8'd1;
                if (len_calc >= max_len_reg) begin
                    res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                    n = n + 3'd1;
                    mode_calc = ttok_pkg::MODE_DISCARD;
                    len_calc  = 8'd0;
                end else begin
                    mode_calc = ttok_pkg::MODE_TOKEN;
                end
            end
        end

        // Handle the byte in the resulting mode
        if (!done) begin
            case (mode_calc)
                ttok_pkg::MODE_COMMENT: begin
                    if (s_text_byte == ttok_pkg::CH_LF || s_text_byte == ttok_pkg::CH_NUL) begin
                        mode_calc = ttok_pkg::MODE_BETWEEN;
                    end
                end
                ttok_pkg::MODE_DISCARD: begin
                    if (sep) begin
                        mode_calc = ttok_pkg::MODE_BETWEEN;
                    end
                end
                default: begin
                    if (sep) begin
                        if (mode_calc == ttok_pkg::MODE_TOKEN) begin
                            res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                            n = n + 3'd1;
                        end
                        mode_calc = ttok_pkg::MODE_BETWEEN;
                        len_calc  = 8'd0;
                    end else if (s_text_byte == ttok_pkg::CH_SLASH) begin
                        pend_calc = 1'b1;
                    end else if (single) begin
                        // Close any open token, then emit a one-byte token
                        if (mode_calc == ttok_pkg::MODE_TOKEN) begin
                            res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                            n = n + 3'd1;
                        end
                        len_calc = 8'd0;
                        res[n[1:0]] = '{ttok_pkg::KIND_BYTE, s_text_byte};
                        n = n + 3'd1;
                        len_calc = len_calc + 8'd1;
                        res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                        n = n + 3'd1;
                        if (len_calc >= max_len_reg) begin
                            mode_calc = ttok_pkg::MODE_DISCARD;
                        end else begin
                            mode_calc = ttok_pkg::MODE_BETWEEN;
                        end
                        len_calc = 8'd0;
                    end else begin
                        res[n[1:0]] = '{ttok_pkg::KIND_BYTE, s_text_byte};
                        n = n + 3'd1;
                        len_calc = len_calc + 8'd1;
                        if (len_calc >= max_len_reg) begin
                            res[n[1:0]] = '{ttok_pkg::KIND_END, 8'd0};
                            n = n + 3'd1;
                            mode_calc = ttok_pkg::MODE_DISCARD;
                            len_calc  = 8'd0;
                        end else begin
                            mode_calc = ttok_pkg::MODE_TOKEN;
                        end
                    end
                end
            endcase
        end
    end

    // Advance state only on an accepted beat
    always_comb begin
        mode_next = accept ? mode_calc : mode_reg;
        len_next  = accept ? len_calc  : len_reg;
        pend_next = accept ? pend_calc : pend_reg;
    end

    assign q_push      = accept && (n != 3'd0);
    assign q_group.cnt = n;
    assign q_group.res = res;

endmodule

`default_nettype wire

>>> sv/ttok_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ttok_queue (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        push,
    input  ttok_pkg::result_group_t    push_group,
    input  wire                        pop,
    output ttok_pkg::result_group_t    head_group,
    output ttok_pkg::queue_status_t    status
);

    ttok_pkg::result_group_t [ttok_pkg::QUEUE_DEPTH-1:0] entry_reg;
    logic [ttok_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ttok_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ttok_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign status.full  = (count_reg == (ttok_pkg::QUEUE_AW + 1)'(ttok_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_group   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a pushed group
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

`default_nettype wire

>>> sv/ttok_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ttok_back (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  ttok_pkg::result_group_t    head_group,
    input  ttok_pkg::queue_status_t    q_status,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic                       m_kind,
    output logic [7:0]                 m_token_byte,
    output logic                       m_last_of_run
);

    logic [ttok_pkg::RES_IDX_W-1:0] sub_reg, sub_next;
    logic                           valid_reg, valid_next;
    ttok_pkg::result_t              res_reg, res_next;
    logic                           last_reg, last_next;
    logic                           load;
    logic                           is_last;

    assign load    = !valid_reg || m_ready;
    assign is_last = ({1'b0, sub_reg} == (head_group.cnt - 3'd1));

    // Walk the head group one result per beat
    always_comb begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = !q_status.empty;
            if (!q_status.empty) begin
                res_next  = head_group.res[sub_reg];
                last_next = is_last;
                if (is_last) begin
                    q_pop    = 1'b1;
                    sub_next = '0;
                end else begin
                    sub_next = sub_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the output beat
    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_kind        = res_reg.kind;
    assign m_token_byte  = res_reg.token_byte;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire

>>> sv/text_tokenizer_with_comments.sv
// Results of an accepted byte pass the queue, then the output register.
// One text byte per cycle while each byte yields at most one result and
// m_ready stays high; a byte yielding k results takes k output beats, and a
// four-group queue between classifier and output stage absorbs such bursts.
// Reset (aresetn low, synchronous): between tokens, no held slash, length
// limit 64, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module text_tokenizer_with_comments (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_text_byte,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [7:0] cfg_max_token_length,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_kind,
    output logic [7:0] m_token_byte,
    output logic       m_last_of_run
);

    ttok_pkg::queue_status_t q_status;
    ttok_pkg::result_group_t push_group;
    ttok_pkg::result_group_t head_group;
    logic                    q_push;
    logic                    q_pop;

    // Take configuration at any time
    assign cfg_ready = 1'b1;

    // Classify bytes and form result groups
    ttok_front u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_text_byte          (s_text_byte),
        .cfg_valid            (cfg_valid),
        .cfg_max_token_length (cfg_max_token_length),
        .q_status             (q_status),
        .q_push               (q_push),
        .q_group              (push_group)
    );

    // Decouple front and back
    ttok_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_group (push_group),
        .pop        (q_pop),
        .head_group (head_group),
        .status     (q_status)
    );

    // Serialise groups onto the result channel
    ttok_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_group    (head_group),
        .q_status      (q_status),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_token_byte  (m_token_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

>>> sv/ttok_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "text_tokenizer_with_comments_macros.svh"

module ttok_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire [7:0] s_text_byte,
    input wire       cfg_valid,
    input wire       cfg_ready,
    input wire [7:0] cfg_max_token_length,
    input wire       m_valid,
    input wire       m_ready,
    input wire       m_kind,
    input wire [7:0] m_token_byte,
    input wire       m_last_of_run
);

    // Stalled result beat holds
    `TTOK_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_token_byte) && $stable(m_last_of_run))

    // End marks carry a zero byte
    `TTOK_ASSERT_HOLDS(a_end_zero, aclk, aresetn, !(m_valid && m_kind) || (m_token_byte == 8'd0))

    // Output is empty right after reset
    `TTOK_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // Configuration is always taken
    `TTOK_ASSERT_HOLDS(a_cfg_ready, aclk, aresetn, cfg_ready || !cfg_valid)

endmodule

bind text_tokenizer_with_comments ttok_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/tb_text_tokenizer_with_comments.sv
`timescale 1ns / 1ps

module tb_text_tokenizer_with_comments;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 10;
    localparam int HOLD_CYCLES = 120;

    // One result beat as the block should present it
    typedef struct packed {
        ttok_pkg::result_kind_t kind;
        logic [7:0]             token_byte;
        logic                   last_of_run;
    } token_beat_t;

    // Tokenizer state mirror and queue of beats still owed by the block
    class token_scoreboard;
        token_beat_t          expected_beats[$];
        ttok_pkg::scan_mode_t mode;
        logic [7:0]           run_len;
        bit                   slash_held;
        logic [7:0]           len_limit;
        int                   errors;

        function new();
            mode       = ttok_pkg::MODE_BETWEEN;
            run_len    = 8'd0;
            slash_held = 1'b0;
            len_limit  = ttok_pkg::MAX_LEN_RESET;
            errors     = 0;
        endfunction

        function void set_limit(logic [7:0] v);
            len_limit = v;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void push_beat(ttok_pkg::result_kind_t k, logic [7:0] c);
            token_beat_t b;
            b.kind        = k;
            b.token_byte  = (k == ttok_pkg::KIND_END) ? 8'h00 : c;
            b.last_of_run = 1'b0;
            expected_beats.push_back(b);
        endfunction

        // Emit a token byte, then close the token on a one-byte token or at the limit
        function void add_token_byte(logic [7:0] c, bit one_byte);
            bit at_limit;
            push_beat(ttok_pkg::KIND_BYTE, c);
            run_len  = run_len + 8'd1;
            at_limit = (run_len >= len_limit);
            if (one_byte || at_limit)
                push_beat(ttok_pkg::KIND_END, 8'h00);
            if (at_limit) begin
                mode    = ttok_pkg::MODE_DISCARD;
                run_len = 8'd0;
            end else if (one_byte) begin
                mode    = ttok_pkg::MODE_BETWEEN;
                run_len = 8'd0;
            end else begin
                mode = ttok_pkg::MODE_TOKEN;
            end
        endfunction

        function void end_open_token();
            if (mode == ttok_pkg::MODE_TOKEN)
                push_beat(ttok_pkg::KIND_END, 8'h00);
            mode    = ttok_pkg::MODE_BETWEEN;
            run_len = 8'd0;
        endfunction

        // Work out the beats one accepted text byte causes
        function void note_byte(logic [7:0] c);
            int start_cnt;
            bit sep;
            bit comment_opened;
            start_cnt      = expected_beats.size();
            sep            = (c == ttok_pkg::CH_SPACE || c == ttok_pkg::CH_LF ||
                              c == ttok_pkg::CH_NUL);
            comment_opened = 1'b0;
            if (slash_held) begin
                slash_held = 1'b0;
                if (c == ttok_pkg::CH_SLASH) begin
                    end_open_token();
                    mode           = ttok_pkg::MODE_COMMENT;
                    comment_opened = 1'b1;
                end else begin
                    add_token_byte(ttok_pkg::CH_SLASH, 1'b0);
                end
            end
            if (!comment_opened) begin
                case (mode)
                    ttok_pkg::MODE_COMMENT: begin
                        if (c == ttok_pkg::CH_LF || c == ttok_pkg::CH_NUL)
                            mode = ttok_pkg::MODE_BETWEEN;
                    end
                    ttok_pkg::MODE_DISCARD: begin
                        if (sep)
                            mode = ttok_pkg::MODE_BETWEEN;
                    end
                    default: begin
                        if (sep) begin
                            end_open_token();
                        end else if (c == ttok_pkg::CH_SLASH) begin
                            slash_held = 1'b1;
                        end else if (c inside {ttok_pkg::CH_LBRACE,
                                               ttok_pkg::CH_RBRACE,
                                               ttok_pkg::CH_QUOTE,
                                               ttok_pkg::CH_LBRACK,
                                               ttok_pkg::CH_RBRACK}) begin
                            end_open_token();
                            add_token_byte(c, 1'b1);
                        end else begin
                            add_token_byte(c, 1'b0);
                        end
                    end
                endcase
            end
            if (expected_beats.size() > start_cnt)
                expected_beats[expected_beats.size() - 1].last_of_run = 1'b1;
        endfunction

        // Compare one accepted beat with the oldest one owed
        function void check_beat(logic kind, logic [7:0] tbyte, logic last);
            token_beat_t exp_beat;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat kind=%0b byte=%02h last=%0b",
                         $time, kind, tbyte, last);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (kind !== exp_beat.kind) begin
                $display("%0t: kind expected %0b actual %0b", $time, exp_beat.kind, kind);
                errors++;
            end
            if (tbyte !== exp_beat.token_byte) begin
                $display("%0t: token_byte expected %02h actual %02h",
                         $time, exp_beat.token_byte, tbyte);
                errors++;
            end
            if (last !== exp_beat.last_of_run) begin
                $display("%0t: last_of_run expected %0b actual %0b",
                         $time, exp_beat.last_of_run, last);
                errors++;
            end
        endfunction
    endclass

    logic       aclk                 = 1'b0;
    logic       aresetn              = 1'b0;
    logic       s_valid              = 1'b0;
    logic [7:0] s_text_byte          = 8'h00;
    logic       cfg_valid            = 1'b0;
    logic [7:0] cfg_max_token_length = 8'h00;
    logic       m_ready              = 1'b0;
    wire        s_ready;
    wire        cfg_ready;
    wire        m_valid;
    wire        m_kind;
    wire  [7:0] m_token_byte;
    wire        m_last_of_run;

    token_scoreboard sb = new();
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int bytes_sent   = 0;

    text_tokenizer_with_comments i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_text_byte          (s_text_byte),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_max_token_length (cfg_max_token_length),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_kind               (m_kind),
        .m_token_byte         (m_token_byte),
        .m_last_of_run        (m_last_of_run)
    );

    always #CLK_HALF aclk = ~aclk;

    // Receiver: long hold-off on request, always ready when quiet, otherwise random back-pressure
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 7);
        end
    end

    // Check every result beat taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_kind, m_token_byte, m_last_of_run);
    end

    // Offer one text byte and hold it until taken; idle now and then unless quiet
    task automatic send_byte(input logic [7:0] b);
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
        if (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i]);
    endtask

    // Drop valid, drain all owed beats, let the pipeline empty, then write the limit
    task automatic write_limit(input logic [7:0] v);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid            <= 1'b1;
        cfg_max_token_length <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.set_limit(v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] word_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(8'h61, 8'h7A));
        else if (r < 80)
            return ($urandom_range(1)) ? 8'h09 : 8'h0D;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    // Mostly words, comments and one-byte tokens with random content; some noise
    task automatic send_traffic(input int n_items);
        int target;
        int r;
        int len;
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            r = $urandom_range(99);
            if (r < 55) begin
                len = $urandom_range(1, 8);
                repeat (len) send_byte(word_byte());
                r = $urandom_range(9);
                send_byte((r < 6) ? ttok_pkg::CH_SPACE :
                          (r < 9) ? ttok_pkg::CH_LF : ttok_pkg::CH_NUL);
            end else if (r < 70) begin
                send_byte(ttok_pkg::CH_SLASH);
                send_byte(ttok_pkg::CH_SLASH);
                repeat ($urandom_range(0, 5)) send_byte(word_byte());
                send_byte(($urandom_range(3) == 0) ? ttok_pkg::CH_NUL : ttok_pkg::CH_LF);
            end else if (r < 82) begin
                r = $urandom_range(4);
                send_byte((r == 0) ? ttok_pkg::CH_LBRACE :
                          (r == 1) ? ttok_pkg::CH_RBRACE :
                          (r == 2) ? ttok_pkg::CH_QUOTE  :
                          (r == 3) ? ttok_pkg::CH_LBRACK : ttok_pkg::CH_RBRACK);
            end else if (r < 88) begin
                send_byte(ttok_pkg::CH_SLASH);
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Run limit
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_text_tokenizer_with_comments: done, errors");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset limit: tab and CR in a token, one-byte tokens,
        // high bytes, comment with a slash inside, lone slash, slash held to end of text
        send_text("a\t\r{b}\"[] ");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("x//c/m\np/q/");
        send_byte(ttok_pkg::CH_NUL);

        // Directed, shortest limit: truncation with a slash discarded,
        // held slash reaching the limit
        write_limit(8'd2);
        send_text("abc/ a/x\n");

        // Longest limit
        write_limit(8'd255);
        send_traffic(25);

        write_limit(8'd2);
        send_traffic(25);

        // Stretch with no idling on either side
        write_limit(8'($urandom_range(3, 6)));
        quiet = 1'b1;
        send_traffic(25);
        quiet = 1'b0;

        // Receiver holds off while bytes keep coming
        write_limit(8'($urandom_range(3, 8)));
        hold_request = 1'b1;
        send_traffic(35);

        write_limit(8'($urandom_range(2, 255)));
        send_traffic(20);

        write_limit(8'd4);
        send_traffic(15);

        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_text_tokenizer_with_comments: done, clean");
        else
            $display("tb_text_tokenizer_with_comments: done, errors");
        $finish;
    end

endmodule
